[rtl/core/skts_pkg.sv]
// Package: types, microcode encoding and control store of the sorted key table search.
`timescale 1ns / 1ps

package skts_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned POS_W = 6;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] year;
    logic [PAY_W-1:0] value;
    logic             last;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [PAY_W-1:0] payload;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_DISPATCH = 4'd1,
    S_SINIT    = 4'd2,
    S_SCHK     = 4'd3,
    S_SRDI     = 4'd4,
    S_SGRAB    = 4'd5,
    S_SRDJ     = 4'd6,
    S_SCMP     = 4'd7,
    S_SPLACE   = 4'd8,
    S_QINIT    = 4'd9,
    S_QRD      = 4'd10,
    S_QCMP     = 4'd11,
    S_QSTEP    = 4'd12,
    S_QMISS    = 4'd13,
    S_QHIT     = 4'd14
  } step_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SINIT,
    OP_RDI,
    OP_GRAB,
    OP_RDJ,
    OP_SHIFT,
    OP_PLACE,
    OP_QINIT,
    OP_QRD,
    OP_QSTEP,
    OP_MISS,
    OP_HIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE_HOLD,
    C_QUERY,
    C_I_DONE,
    C_J_ZERO,
    C_KEY_GT,
    C_EMPTY,
    C_MATCH,
    C_SEARCHING
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cnd;
    step_e tgt;
  } uinstr_t;

  // control store: jump to tgt when cnd holds, else fall through
  function automatic uinstr_t ucode_rom(input step_e s);
    uinstr_t u;
    case (s)
      S_IDLE:     u = '{op: OP_ACCEPT, cnd: C_IDLE_HOLD, tgt: S_IDLE};
      S_DISPATCH: u = '{op: OP_NOP,    cnd: C_QUERY,     tgt: S_QINIT};
      S_SINIT:    u = '{op: OP_SINIT,  cnd: C_NEVER,     tgt: S_IDLE};
      S_SCHK:     u = '{op: OP_NOP,    cnd: C_I_DONE,    tgt: S_IDLE};
      S_SRDI:     u = '{op: OP_RDI,    cnd: C_NEVER,     tgt: S_IDLE};
      S_SGRAB:    u = '{op: OP_GRAB,   cnd: C_NEVER,     tgt: S_IDLE};
      S_SRDJ:     u = '{op: OP_RDJ,    cnd: C_J_ZERO,    tgt: S_SPLACE};
      S_SCMP:     u = '{op: OP_SHIFT,  cnd: C_KEY_GT,    tgt: S_SRDJ};
      S_SPLACE:   u = '{op: OP_PLACE,  cnd: C_ALWAYS,    tgt: S_SCHK};
      S_QINIT:    u = '{op: OP_QINIT,  cnd: C_EMPTY,     tgt: S_QMISS};
      S_QRD:      u = '{op: OP_QRD,    cnd: C_NEVER,     tgt: S_IDLE};
      S_QCMP:     u = '{op: OP_NOP,    cnd: C_MATCH,     tgt: S_QHIT};
      S_QSTEP:    u = '{op: OP_QSTEP,  cnd: C_SEARCHING, tgt: S_QRD};
      S_QMISS:    u = '{op: OP_MISS,   cnd: C_ALWAYS,    tgt: S_IDLE};
      S_QHIT:     u = '{op: OP_HIT,    cnd: C_ALWAYS,    tgt: S_IDLE};
      default:    u = '{op: OP_NOP,    cnd: C_ALWAYS,    tgt: S_IDLE};
    endcase
    return u;
  endfunction

endpackage

[rtl/core/sorted_key_table_search_top.sv]
// Sorted key table search: microcoded load, stable insertion sort and binary search.
// Load beat: stored while idle if there is room; last set starts the sort. Sort of n records:
//   each is held as the key while greater records below it shift up, then it is placed.
// Query: probe mid, compare, step bounds (at most floor(log2(n))+1 probes) until hit or miss;
//   result strobe on the cycle busy falls; the receiver cannot stall, so no output holding.
// Reset: asynchronous, active low; clears counts and sequencer, record memory is not cleared.
`timescale 1ns / 1ps

module sorted_key_table_search_top
  import skts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  req_i,
  output logic res_valid_o,
  output out_t res_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  rec_t mem [TABLE_DEPTH];

  step_e          upc_q, upc_d;
  logic [CW-1:0]  lptr_q, lptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  i_q, i_d;
  logic [AW-1:0]  j_q, j_d;
  logic [CW-1:0]  lo_q, lo_d;
  logic [CW-1:0]  hp_q, hp_d;   // hi + 1
  logic [AW-1:0]  mid_q, mid_d;
  rec_t           k_q, k_d;
  rec_t           rd_q;
  logic [KEY_W-1:0] yr_q, yr_d;
  logic           act_q, act_d;
  logic           res_valid_q, res_valid_d;
  out_t           res_q, res_d;

  uinstr_t        uw;
  logic           cnd_true;
  logic           accept;
  logic           we;
  logic [AW-1:0]  waddr;
  rec_t           wdata;
  logic           re;
  logic [AW-1:0]  raddr;
  logic [SW-1:0]  sum;
  logic [SW-1:0]  sum_m1;
  logic [AW-1:0]  mid_c;
  logic [CW-1:0]  lptr_inc;

  assign uw     = ucode_rom(upc_q);
  assign busy   = (upc_q != S_IDLE);
  assign accept = start && !busy;

  assign sum    = SW'(lo_q) + SW'(hp_q);
  assign sum_m1 = sum - SW'(1);
  assign mid_c  = (sum == '0) ? '0 : AW'(sum_m1 >> 1);
  assign lptr_inc = lptr_q + CW'(1);

  always_comb begin
    case (uw.cnd)
      C_NEVER:     cnd_true = 1'b0;
      C_ALWAYS:    cnd_true = 1'b1;
      C_IDLE_HOLD: cnd_true = !start || (req_i.action == ACT_LOAD && !req_i.last);
      C_QUERY:     cnd_true = (act_q == ACT_QUERY);
      C_I_DONE:    cnd_true = (i_q >= cnt_q);
      C_J_ZERO:    cnd_true = (j_q == '0);
      C_KEY_GT:    cnd_true = (rd_q.key > k_q.key);
      C_EMPTY:     cnd_true = (cnt_q == '0);
      C_MATCH:     cnd_true = (rd_q.key == yr_q);
      C_SEARCHING: cnd_true = ((SW'(lo_q) + SW'(1)) < SW'(hp_q));
      default:     cnd_true = 1'b1;
    endcase
  end

  always_comb begin
    upc_d = cnd_true ? uw.tgt : step_e'(upc_q + 4'd1);
  end

  always_comb begin
    lptr_d      = lptr_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hp_d        = hp_q;
    mid_d       = mid_q;
    k_d         = k_q;
    yr_d        = yr_q;
    act_d       = act_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = j_q;
    wdata       = k_q;
    re          = 1'b0;
    raddr       = i_q[AW-1:0];
    case (uw.op)
      OP_ACCEPT: begin
        if (accept) begin
          act_d = req_i.action;
          yr_d  = req_i.year;
          if (req_i.action == ACT_LOAD) begin
            cnt_d = '0;
            if (lptr_q < CW'(TABLE_DEPTH)) begin
              we     = 1'b1;
              waddr  = lptr_q[AW-1:0];
              wdata  = '{key: req_i.year, pay: req_i.value};
              lptr_d = lptr_inc;
            end
            if (req_i.last) begin
              cnt_d  = (lptr_q < CW'(TABLE_DEPTH)) ? lptr_inc : lptr_q;
              lptr_d = '0;
            end
          end
        end
      end
      OP_SINIT: i_d = CW'(1);
      OP_RDI: begin
        re    = 1'b1;
        raddr = i_q[AW-1:0];
        j_d   = i_q[AW-1:0];
      end
      OP_GRAB: k_d = rd_q;
      OP_RDJ: begin
        re    = (j_q != '0);
        raddr = j_q - AW'(1);
      end
      OP_SHIFT: begin
        if (rd_q.key > k_q.key) begin
          we    = 1'b1;
          waddr = j_q;
          wdata = rd_q;
          j_d   = j_q - AW'(1);
        end
      end
      OP_PLACE: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = k_q;
        i_d   = i_q + CW'(1);
      end
      OP_QINIT: begin
        lo_d = '0;
        hp_d = cnt_q;
      end
      OP_QRD: begin
        re    = 1'b1;
        raddr = mid_c;
        mid_d = mid_c;
      end
      OP_QSTEP: begin
        if (yr_q < rd_q.key) begin
          hp_d = CW'(mid_q);
        end else begin
          lo_d = CW'(mid_q) + CW'(1);
        end
      end
      OP_MISS: begin
        res_valid_d = 1'b1;
        res_d       = '0;
      end
      OP_HIT: begin
        res_valid_d = 1'b1;
        res_d       = '{found: 1'b1, position: POS_W'(mid_q), payload: rd_q.pay};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= S_IDLE;
      lptr_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      lptr_q      <= lptr_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    lo_q  <= lo_d;
    hp_q  <= hp_d;
    mid_q <= mid_d;
    k_q   <= k_d;
    yr_q  <= yr_d;
    act_q <= act_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |-> (res_o.position == '0 && res_o.payload == '0))
    else $error("miss carries non-zero fields");

  a_counts_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lptr_q <= CW'(TABLE_DEPTH)) && (cnt_q <= CW'(TABLE_DEPTH)))
    else $error("load pointer or entry count beyond table depth");

  a_batch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.action == ACT_LOAD && !req_i.last) |=> (cnt_q == '0 && !busy))
    else $error("open batch left a searchable table");

endmodule

[bench/skts_result_checker.sv]
// Checker for the sorted key table search: tracks accepted beats, predicts answers, compares.
`timescale 1ns / 1ps

module skts_result_checker
  import skts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_t         req_i,
  input  logic        res_valid_i,
  input  out_t        res_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
  logic [PAY_W-1:0] table_pays [TABLE_DEPTH];
  int unsigned      sorted_count = 0;
  int unsigned      fill_ptr     = 0;
  int unsigned      bad_beats    = 0;
  int unsigned      checked      = 0;
  out_t             answers_due[$];

  // stable: equal keys stay in load order
  task automatic sort_table(input int unsigned n);
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] p;
    int unsigned      j;
    for (int unsigned i = 1; i < n; i++) begin
      k = table_keys[i];
      p = table_pays[i];
      j = i;
      while (j > 0 && table_keys[j-1] > k) begin
        table_keys[j] = table_keys[j-1];
        table_pays[j] = table_pays[j-1];
        j--;
      end
      table_keys[j] = k;
      table_pays[j] = p;
    end
  endtask

  task automatic store_load(input in_t b);
    sorted_count = 0;
    if (fill_ptr < TABLE_DEPTH) begin
      table_keys[fill_ptr] = b.year;
      table_pays[fill_ptr] = b.value;
      fill_ptr++;
    end
    if (b.last) begin
      sorted_count = fill_ptr;
      sort_table(sorted_count);
      fill_ptr = 0;
    end
  endtask

  function automatic out_t lookup_year(input logic [KEY_W-1:0] yr);
    out_t r;
    int   lo;
    int   hi;
    int   mid;
    bit   done;
    r    = '0;
    done = 1'b0;
    if (sorted_count > 0) begin
      lo = 0;
      hi = int'(sorted_count) - 1;
      while (!done) begin
        mid = (lo + hi) / 2;
        if (mid < 0 || mid >= int'(sorted_count)) begin
          done = 1'b1;
        end else if (table_keys[mid] == yr) begin
          r.found    = 1'b1;
          r.position = mid[POS_W-1:0];
          r.payload  = table_pays[mid];
          done       = 1'b1;
        end else if (lo >= hi) begin
          done = 1'b1;
        end else if (yr < table_keys[mid]) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        if (req_i.action == ACT_QUERY) begin
          answers_due.push_back(lookup_year(req_i.year));
        end else begin
          store_load(req_i);
        end
      end
      if (res_valid_i) begin
        checked++;
        if (answers_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t: unexpected result beat %0d: found=%0b pos=%0d payload=%h",
                     $realtime, checked, res_i.found, res_i.position, res_i.payload);
        end else begin
          want = answers_due.pop_front();
          if (res_i.found !== want.found || res_i.position !== want.position ||
              res_i.payload !== want.payload) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("%0t: beat %0d: expected %0b/%0d/%h, got %0b/%0d/%h",
                       $realtime, checked, want.found, want.position, want.payload,
                       res_i.found, res_i.position, res_i.payload);
          end
        end
      end
      mismatches_o <= bad_beats;
      pending_o    <= answers_due.size();
    end
  end

endmodule

[bench/sorted_key_table_search_top_tb.sv]
// Testbench top for the sorted key table search: clock, reset, load and query stimulus, verdict.
`timescale 1ns / 1ps

module sorted_key_table_search_top_tb;
  import skts_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned ITEM_TARGET = 1600;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  in_t         req    = '0;
  logic        busy;
  logic        res_valid;
  out_t        res;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  bit          quiet      = 1'b0;
  logic [KEY_W-1:0] batch_years[$];

  sorted_key_table_search_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  skts_result_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // start is left high so back-to-back beats need no second assignment
  task automatic send(input in_t beat);
    start <= 1'b1;
    req   <= beat;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic idle(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!quiet) begin
      if (r >= 92) idle($urandom_range(8, 40));
      else if (r >= 60) idle($urandom_range(1, 3));
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic in_t load_beat(input logic [KEY_W-1:0] yr, input logic [PAY_W-1:0] val,
                                    input logic fin);
    in_t b;
    b.action = ACT_LOAD;
    b.year   = yr;
    b.value  = val;
    b.last   = fin;
    return b;
  endfunction

  // value and last are don't-care on a query, so they are scrambled
  function automatic in_t query_beat(input logic [KEY_W-1:0] yr);
    in_t b;
    b.action = ACT_QUERY;
    b.year   = yr;
    b.value  = $urandom;
    b.last   = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic logic [KEY_W-1:0] pick_year(input int unsigned mode,
                                                 input int unsigned base);
    case (mode)
      0:       return KEY_W'($urandom_range(0, 65535));
      1:       return KEY_W'(base + $urandom_range(0, 7));
      default: return $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 3))
                                           : KEY_W'($urandom_range(65532, 65535));
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_query();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = batch_years.size();
    if (n > 0 && r < 60)
      return batch_years[$urandom_range(0, n - 1)];
    if (n > 0 && r < 75)
      return batch_years[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
    return KEY_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int unsigned      batch_no;
    int unsigned      mode;
    int unsigned      base;
    int unsigned      nload;
    int unsigned      nq;
    logic [KEY_W-1:0] yr;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table straight after reset
    send(query_beat(16'h0000));
    send(query_beat(16'hFFFF));
    // single record at the key and payload extremes
    gap(); send(load_beat(16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    gap(); send(query_beat(16'hFFFF));
    send(query_beat(16'h0000));
    // duplicates must keep load order; both key extremes present
    gap(); send(load_beat(16'd100,   32'hA5A5_5A5A, 1'b0));
    send(load_beat(16'd0,     32'h0000_0000, 1'b0));
    send(load_beat(16'hFFFF,  32'h8000_0001, 1'b0));
    gap(); send(load_beat(16'd100,   32'h1234_5678, 1'b0));
    send(load_beat(16'd50,    32'h7FFF_FFFE, 1'b0));
    send(load_beat(16'd100,   32'hDEAD_BEEF, 1'b1));
    send(query_beat(16'd100));
    send(query_beat(16'd0));
    gap(); send(query_beat(16'hFFFF));
    send(query_beat(16'd50));
    send(query_beat(16'd99));
    send(query_beat(16'd101));
    // query while a batch is still open answers not found
    gap(); send(load_beat(16'd7, 32'h5555_AAAA, 1'b0));
    send(query_beat(16'd7));
    send(load_beat(16'd3, 32'hAAAA_5555, 1'b1));
    send(query_beat(16'd7));
    send(query_beat(16'd3));

    batch_no = 0;
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 3) == 0);
      mode  = $urandom_range(0, 2);
      base  = $urandom_range(0, 65528);
      if (batch_no % 15 == 3)
        nload = $urandom_range(DEPTH - 2, DEPTH + 8);
      else if ($urandom_range(0, 9) < 7)
        nload = $urandom_range(1, 8);
      else
        nload = $urandom_range(9, 40);
      batch_years.delete();
      for (int unsigned i = 0; i < nload; i++) begin
        yr = pick_year(mode, base);
        batch_years.push_back(yr);
        gap();
        send(load_beat(yr, $urandom, i == nload - 1));
        if (i != nload - 1 && $urandom_range(0, 24) == 0) begin
          gap();
          send(query_beat(pick_query()));
        end
      end
      if (batch_no == 5 || $urandom_range(0, 11) == 0)
        drain();
      nq = $urandom_range(1, 10);
      for (int unsigned i = 0; i < nq; i++) begin
        gap();
        send(query_beat(pick_query()));
      end
      batch_no++;
    end

    drain();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
